/* rtl/spot_light_froxel_cull_test_top_macros.svh */
// assertion macros used by the checker file
`ifndef SPOT_LIGHT_FROXEL_CULL_TEST_TOP_MACROS_SVH
`define SPOT_LIGHT_FROXEL_CULL_TEST_TOP_MACROS_SVH

// same-cycle implication on clk_i, off during reset
`define SFC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfc check failed");

// next-cycle implication on clk_i, off during reset
`define SFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfc check failed");

`endif

/* rtl/sfc_pkg.sv */
// shared constants and types of the spot light froxel cull test
package sfc_pkg;

  localparam int AXIS_W     = 16;
  localparam int SIN_INV_W  = 23;
  localparam int COS_SQ_W   = 16;
  localparam int CFG_DATA_W = 23;
  localparam int CFG_IDX_W  = 3;

  localparam logic [SIN_INV_W-1:0] SIN_INV_CAP   = 23'd7509946;
  localparam logic [SIN_INV_W-1:0] SIN_INV_RESET = 23'd65536;
  localparam logic [COS_SQ_W-1:0]  COS_SQ_CAP    = 16'd65531;
  localparam logic [AXIS_W-1:0]    AXIS_Z_RESET  = 16'hC000;

  // sin-inverse fraction plus axis fraction
  localparam int APEX_SHIFT = 30;
  // two axis fractions minus the cosine fraction
  localparam int RHS_SHIFT  = 12;

  localparam int LIMB_W  = 32;
  localparam int MUL_LAT = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPOT_ENABLE = 3'd0,
    REG_AXIS_X      = 3'd1,
    REG_AXIS_Y      = 3'd2,
    REG_AXIS_Z      = 3'd3,
    REG_SIN_INV     = 3'd4,
    REG_COS_SQ      = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic pp;
    logic row;
    logic sum;
  } mul_en_t;

endpackage

/* rtl/sfc_if.sv */
// stream interfaces for the light/froxel pairs and the cull results
interface sfc_in_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] light_x;
  logic signed [COORD_WIDTH-1:0] light_y;
  logic signed [COORD_WIDTH-1:0] light_z;
  logic        [COORD_WIDTH-2:0] light_radius;
  logic signed [COORD_WIDTH-1:0] froxel_center_x;
  logic signed [COORD_WIDTH-1:0] froxel_center_y;
  logic signed [COORD_WIDTH-1:0] froxel_center_z;
  logic        [COORD_WIDTH-2:0] froxel_radius;

  modport source (
    output valid, light_x, light_y, light_z, light_radius,
    output froxel_center_x, froxel_center_y, froxel_center_z, froxel_radius,
    input  ready
  );
  modport sink (
    input  valid, light_x, light_y, light_z, light_radius,
    input  froxel_center_x, froxel_center_y, froxel_center_z, froxel_radius,
    output ready
  );
endinterface

interface sfc_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic sphere_hit;

  modport source (output valid, hit, sphere_hit, input ready);
  modport sink (input valid, hit, sphere_hit, output ready);
endinterface

/* rtl/sfc_mul.sv */
// unsigned multiplier split into limb products, row sums and a final sum
module sfc_mul
  import sfc_pkg::*;
#(
  parameter int A_W = 32,
  parameter int B_W = 32
) (
  input  logic               clk_i,
  input  mul_en_t            en_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0] p_o
);

  localparam int NA    = (A_W + LIMB_W - 1) / LIMB_W;
  localparam int NB    = (B_W + LIMB_W - 1) / LIMB_W;
  localparam int PP_W  = 2 * LIMB_W;
  localparam int ROW_W = (NB + 1) * LIMB_W;
  localparam int ACC_W = (NA + NB) * LIMB_W;
  localparam int P_W   = A_W + B_W;

  logic [NA*LIMB_W-1:0] a_pad;
  logic [NB*LIMB_W-1:0] b_pad;
  logic [PP_W-1:0]      pp_q  [NA][NB];
  logic [ROW_W-1:0]     row_d [NA];
  logic [ROW_W-1:0]     row_q [NA];
  logic [ACC_W-1:0]     acc_d;
  logic [P_W-1:0]       p_q;

  assign a_pad = (NA*LIMB_W)'(a_i);
  assign b_pad = (NB*LIMB_W)'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i.pp) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= a_pad[i*LIMB_W +: LIMB_W] * b_pad[j*LIMB_W +: LIMB_W];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (ROW_W'(pp_q[i][j]) << (j * LIMB_W));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.row) begin
      row_q <= row_d;
    end
  end

  always_comb begin
    acc_d = '0;
    for (int i = 0; i < NA; i++) begin
      acc_d = acc_d + (ACC_W'(row_q[i]) << (i * LIMB_W));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      p_q <= acc_d[P_W-1:0];
    end
  end

  assign p_o = p_q;

endmodule

/* rtl/spot_light_froxel_cull_test_top.sv */
// Spot light froxel cull test top level. Takes one light/froxel pair per clock
// unless the full pipe is stalled, and returns one result per pair, in order. Depth
// comes from four exact multiplies in a row (sphere squares and apex scale, the
// apex offset, the offset vector squares and axis products, and the final square
// against the cosine term), each split into 32x32 limb products, a row sum and a
// final sum over three register stages. Each stage has its own valid bit and, when
// full, holds only while the stage after it holds, so bubbles close up under a
// stall and the input keeps taking pairs until the whole pipe is full. The user
// must keep configuration static while pairs are in flight, unchecked by the block.
// Out-of-range sine-inverse and cosine-squared writes are clamped to their caps.
module spot_light_froxel_cull_test_top
  import sfc_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sfc_in_if.sink                in_chan,
  sfc_out_if.source             out_chan,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int W        = COORD_WIDTH;
  localparam int RADIUS_W = W - 1;
  localparam int DIFF_W   = W + 1;
  localparam int RR_W     = W;
  localparam int TSQ_W    = 2 * DIFF_W;
  localparam int DSUM_W   = TSQ_W + 2;
  localparam int RRSQ_W   = 2 * RR_W;
  localparam int K_W      = RADIUS_W + SIN_INV_W;
  localparam int KA_W     = K_W + AXIS_W;
  localparam int OFS_W    = DIFF_W + APEX_SHIFT;
  localparam int DM_W     = ((OFS_W - 1 > KA_W) ? OFS_W - 1 : KA_W) + 1;
  localparam int D_W      = DM_W + 1;
  localparam int DSQ_W    = 2 * DM_W;
  localparam int DD_W     = DSQ_W + 2;
  localparam int AD_W     = AXIS_W + DM_W;
  localparam int E_W      = AD_W + 2;
  localparam int ESQ_W    = 2 * E_W;
  localparam int RHS_W    = DD_W + COS_SQ_W;
  localparam int CMP_W    = (ESQ_W > RHS_W + RHS_SHIFT) ? ESQ_W : RHS_W + RHS_SHIFT;

  localparam int ST_IN  = 1;
  localparam int ST_SQ  = ST_IN + 1;
  localparam int ST_KA  = ST_SQ + MUL_LAT;
  localparam int ST_D   = ST_KA + MUL_LAT;
  localparam int ST_DSQ = ST_D + 1;
  localparam int ST_SUM = ST_DSQ + MUL_LAT;
  localparam int ST_E   = ST_SUM + 1;
  localparam int ST_ESQ = ST_E + 1;
  localparam int ST_OUT = ST_ESQ + MUL_LAT;

  // configuration
  logic                 spot_q;
  logic [AXIS_W-1:0]    axis_q [3];
  logic [SIN_INV_W-1:0] sin_inv_q;
  logic [COS_SQ_W-1:0]  cos_sq_q;
  logic [AXIS_W-1:0]    axm [3];

  // handshake
  logic [ST_OUT:ST_IN]   v_q;
  logic [ST_OUT+1:ST_IN] en;

  // stage signals
  logic signed [W-1:0]      lpos [3];
  logic signed [W-1:0]      cpos [3];
  logic signed [DIFF_W-1:0] dlc [3];
  logic signed [DIFF_W-1:0] dcl_d [3];
  logic [DIFF_W-1:0]        tabs_d [3];
  logic [DIFF_W-1:0]        tabs_q [3];
  logic [RR_W-1:0]          rr_q;
  logic [RADIUS_W-1:0]      fr_q;
  logic signed [DIFF_W-1:0] dcl_q [ST_IN:ST_D-1][3];

  logic [TSQ_W-1:0]  tsq_w [3];
  logic [RRSQ_W-1:0] rrsq_w;
  logic [K_W-1:0]    k_w;
  logic [KA_W-1:0]   ka_w [3];
  logic              sph_q [ST_KA:ST_OUT-1];

  logic signed [D_W-1:0] ofs [3];
  logic signed [D_W-1:0] kext [3];
  logic signed [D_W-1:0] dval [3];
  logic [D_W-1:0]        dmag [3];
  logic [DM_W-1:0]       dabs_q [3];
  logic                  dneg_q [ST_D:ST_SUM-1][3];

  logic [DSQ_W-1:0] dsq_w [3];
  logic [AD_W-1:0]  ad_w [3];
  logic [DD_W-1:0]  dd_d;
  logic [DD_W-1:0]  dd_q;
  logic [E_W-1:0]   psum_d;
  logic [E_W-1:0]   nsum_d;
  logic [E_W-1:0]   psum_q;
  logic [E_W-1:0]   nsum_q;
  logic [E_W-1:0]   eabs_q;
  logic [DD_W-1:0]  dde_q;
  logic             epos_q [ST_E:ST_OUT-1];

  logic [ESQ_W-1:0] esq_w;
  logic [RHS_W-1:0] rhs_w;
  logic             cone_ge;
  logic             hit_q;
  logic             sph_hit_q;

  mul_en_t en_sq;
  mul_en_t en_ka;
  mul_en_t en_dsq;
  mul_en_t en_esq;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spot_q    <= 1'b0;
      axis_q[0] <= '0;
      axis_q[1] <= '0;
      axis_q[2] <= AXIS_Z_RESET;
      sin_inv_q <= SIN_INV_RESET;
      cos_sq_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SPOT_ENABLE: begin
          spot_q <= cfg_wdata_i[0];
        end
        REG_AXIS_X: begin
          axis_q[0] <= cfg_wdata_i[AXIS_W-1:0];
        end
        REG_AXIS_Y: begin
          axis_q[1] <= cfg_wdata_i[AXIS_W-1:0];
        end
        REG_AXIS_Z: begin
          axis_q[2] <= cfg_wdata_i[AXIS_W-1:0];
        end
        REG_SIN_INV: begin
          sin_inv_q <= (cfg_wdata_i[SIN_INV_W-1:0] > SIN_INV_CAP) ?
                       SIN_INV_CAP : cfg_wdata_i[SIN_INV_W-1:0];
        end
        REG_COS_SQ: begin
          cos_sq_q <= (cfg_wdata_i[COS_SQ_W-1:0] > COS_SQ_CAP) ?
                      COS_SQ_CAP : cfg_wdata_i[COS_SQ_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      axm[i] = axis_q[i][AXIS_W-1] ? (~axis_q[i] + 1'b1) : axis_q[i];
    end
  end

  // per-stage valid and hold
  always_comb begin
    en[ST_OUT+1] = out_chan.ready;
    for (int k = ST_OUT; k >= ST_IN; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[ST_IN]) begin
        v_q[ST_IN] <= in_chan.valid;
      end
      for (int k = ST_IN + 1; k <= ST_OUT; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_chan.ready  = en[ST_IN];
  assign out_chan.valid = v_q[ST_OUT];

  assign en_sq  = '{pp: en[ST_SQ],  row: en[ST_SQ+1],  sum: en[ST_SQ+2]};
  assign en_ka  = '{pp: en[ST_KA],  row: en[ST_KA+1],  sum: en[ST_KA+2]};
  assign en_dsq = '{pp: en[ST_DSQ], row: en[ST_DSQ+1], sum: en[ST_DSQ+2]};
  assign en_esq = '{pp: en[ST_ESQ], row: en[ST_ESQ+1], sum: en[ST_ESQ+2]};

  // input stage: center differences and radius sum
  assign lpos[0] = in_chan.light_x;
  assign lpos[1] = in_chan.light_y;
  assign lpos[2] = in_chan.light_z;
  assign cpos[0] = in_chan.froxel_center_x;
  assign cpos[1] = in_chan.froxel_center_y;
  assign cpos[2] = in_chan.froxel_center_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dlc[i]    = DIFF_W'(lpos[i]) - DIFF_W'(cpos[i]);
      dcl_d[i]  = DIFF_W'(cpos[i]) - DIFF_W'(lpos[i]);
      tabs_d[i] = dlc[i][DIFF_W-1] ? -dlc[i] : dlc[i];
    end
  end

  // apex offset vector and its magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ofs[i]  = D_W'(dcl_q[ST_D-1][i]) <<< APEX_SHIFT;
      kext[i] = D_W'(ka_w[i]);
      dval[i] = axis_q[i][AXIS_W-1] ? (ofs[i] - kext[i]) : (ofs[i] + kext[i]);
      dmag[i] = dval[i][D_W-1] ? -dval[i] : dval[i];
    end
  end

  // |d|^2 and the axis dot product split by sign
  always_comb begin
    dd_d   = '0;
    psum_d = '0;
    nsum_d = '0;
    for (int i = 0; i < 3; i++) begin
      dd_d = dd_d + DD_W'(dsq_w[i]);
      if (axis_q[i][AXIS_W-1] ^ dneg_q[ST_SUM-1][i]) begin
        nsum_d = nsum_d + E_W'(ad_w[i]);
      end else begin
        psum_d = psum_d + E_W'(ad_w[i]);
      end
    end
  end

  assign cone_ge = CMP_W'(esq_w) >= (CMP_W'(rhs_w) << RHS_SHIFT);

  always_ff @(posedge clk_i) begin
    if (en[ST_IN]) begin
      tabs_q       <= tabs_d;
      rr_q         <= RR_W'(in_chan.light_radius) + RR_W'(in_chan.froxel_radius);
      fr_q         <= in_chan.froxel_radius;
      dcl_q[ST_IN] <= dcl_d;
    end
    for (int k = ST_IN + 1; k < ST_D; k++) begin
      if (en[k]) begin
        dcl_q[k] <= dcl_q[k-1];
      end
    end
    if (en[ST_KA]) begin
      sph_q[ST_KA] <= DSUM_W'(rrsq_w) >=
                      DSUM_W'(tsq_w[0]) + DSUM_W'(tsq_w[1]) + DSUM_W'(tsq_w[2]);
    end
    for (int k = ST_KA + 1; k < ST_OUT; k++) begin
      if (en[k]) begin
        sph_q[k] <= sph_q[k-1];
      end
    end
    if (en[ST_D]) begin
      for (int i = 0; i < 3; i++) begin
        dabs_q[i]      <= dmag[i][DM_W-1:0];
        dneg_q[ST_D][i] <= dval[i][D_W-1];
      end
    end
    for (int k = ST_D + 1; k < ST_SUM; k++) begin
      if (en[k]) begin
        dneg_q[k] <= dneg_q[k-1];
      end
    end
    if (en[ST_SUM]) begin
      dd_q   <= dd_d;
      psum_q <= psum_d;
      nsum_q <= nsum_d;
    end
    if (en[ST_E]) begin
      epos_q[ST_E] <= psum_q > nsum_q;
      eabs_q       <= psum_q - nsum_q;
      dde_q        <= dd_q;
    end
    for (int k = ST_E + 1; k < ST_OUT; k++) begin
      if (en[k]) begin
        epos_q[k] <= epos_q[k-1];
      end
    end
    if (en[ST_OUT]) begin
      hit_q     <= sph_q[ST_OUT-1] && (!spot_q || (epos_q[ST_OUT-1] && cone_ge));
      sph_hit_q <= sph_q[ST_OUT-1];
    end
  end

  assign out_chan.hit        = hit_q;
  assign out_chan.sphere_hit = sph_hit_q;

  // sphere squares and apex scale
  for (genvar i = 0; i < 3; i++) begin : g_tsq
    sfc_mul #(.A_W(DIFF_W), .B_W(DIFF_W)) u_tsq (
      .clk_i (clk_i),
      .en_i  (en_sq),
      .a_i   (tabs_q[i]),
      .b_i   (tabs_q[i]),
      .p_o   (tsq_w[i])
    );
  end

  sfc_mul #(.A_W(RR_W), .B_W(RR_W)) u_rrsq (
    .clk_i (clk_i),
    .en_i  (en_sq),
    .a_i   (rr_q),
    .b_i   (rr_q),
    .p_o   (rrsq_w)
  );

  sfc_mul #(.A_W(RADIUS_W), .B_W(SIN_INV_W)) u_k (
    .clk_i (clk_i),
    .en_i  (en_sq),
    .a_i   (fr_q),
    .b_i   (sin_inv_q),
    .p_o   (k_w)
  );

  // apex offset along each axis component, then d squares and axis products
  for (genvar i = 0; i < 3; i++) begin : g_vec
    sfc_mul #(.A_W(K_W), .B_W(AXIS_W)) u_ka (
      .clk_i (clk_i),
      .en_i  (en_ka),
      .a_i   (k_w),
      .b_i   (axm[i]),
      .p_o   (ka_w[i])
    );

    sfc_mul #(.A_W(DM_W), .B_W(DM_W)) u_dsq (
      .clk_i (clk_i),
      .en_i  (en_dsq),
      .a_i   (dabs_q[i]),
      .b_i   (dabs_q[i]),
      .p_o   (dsq_w[i])
    );

    sfc_mul #(.A_W(AXIS_W), .B_W(DM_W)) u_ad (
      .clk_i (clk_i),
      .en_i  (en_dsq),
      .a_i   (axm[i]),
      .b_i   (dabs_q[i]),
      .p_o   (ad_w[i])
    );
  end

  // cone compare operands
  sfc_mul #(.A_W(E_W), .B_W(E_W)) u_esq (
    .clk_i (clk_i),
    .en_i  (en_esq),
    .a_i   (eabs_q),
    .b_i   (eabs_q),
    .p_o   (esq_w)
  );

  sfc_mul #(.A_W(DD_W), .B_W(COS_SQ_W)) u_rhs (
    .clk_i (clk_i),
    .en_i  (en_esq),
    .a_i   (dde_q),
    .b_i   (cos_sq_q),
    .p_o   (rhs_w)
  );

endmodule

/* rtl/sfc_checker.sv */
// port-level checks of the cull test top level and their bind
`include "spot_light_froxel_cull_test_top_macros.svh"

module sfc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic hit_i,
  input logic sphere_hit_i
);

  // a cone pass never stands without a sphere pass
  `SFC_ASSERT_SAME(a_hit_needs_sphere, out_valid_i && hit_i, sphere_hit_i)

  // input only backs up when the whole pipe is full and the output is stalled
  `SFC_ASSERT_SAME(a_ready_only_on_full_stall, !in_ready_i, out_valid_i && !out_ready_i)

  // stalled result stays put
  `SFC_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(hit_i) && $stable(sphere_hit_i))

endmodule

bind spot_light_froxel_cull_test_top sfc_checker u_sfc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_chan.valid),
  .in_ready_i   (in_chan.ready),
  .out_valid_i  (out_chan.valid),
  .out_ready_i  (out_chan.ready),
  .hit_i        (out_chan.hit),
  .sphere_hit_i (out_chan.sphere_hit)
);

/* tb/testbench.sv */
// self-checking testbench for the spot light froxel cull pipeline
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sfc_pkg::*;

  localparam int CW = 32;
  localparam int U = 65536;
  localparam int RANDOM_PER_PHASE = 270;
  localparam int BURST_ITEMS = 80;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT = 20000;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS = 50;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam logic signed [CW-1:0] MAXC = 32'sh7FFFFFFF;
  localparam logic signed [CW-1:0] MINC = 32'sh80000000;
  localparam logic [CW-2:0] MAXR = 31'h7FFFFFFF;

  typedef struct {
    logic signed [CW-1:0] light_x;
    logic signed [CW-1:0] light_y;
    logic signed [CW-1:0] light_z;
    logic [CW-2:0] light_radius;
    logic signed [CW-1:0] froxel_x;
    logic signed [CW-1:0] froxel_y;
    logic signed [CW-1:0] froxel_z;
    logic [CW-2:0] froxel_radius;
  } cull_pair_t;

  typedef struct packed {
    logic hit;
    logic sphere_hit;
  } cull_result_t;

  typedef struct {
    logic spot_enable;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic [SIN_INV_W-1:0] sin_inv;
    logic [COS_SQ_W-1:0] cos_sq;
  } cull_cfg_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  sfc_in_if #(.COORD_WIDTH(CW)) pair_if ();
  sfc_out_if res_if ();

  cull_cfg_t cfg_model = '{1'b0, 16'sd0, 16'sd0, AXIS_Z_RESET, SIN_INV_RESET, 16'd0};
  cull_result_t expected_q[$];
  int error_count = 0;
  int result_count = 0;
  int stall_count = 0;
  int hold_left = 0;
  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 71;

  spot_light_froxel_cull_test_top #(.COORD_WIDTH(CW)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan    (pair_if),
    .out_chan   (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic cull_result_t cull_predict(cull_pair_t p, cull_cfg_t c);
    logic signed [255:0] lp [3];
    logic signed [255:0] fc [3];
    logic signed [255:0] ax [3];
    logic signed [255:0] d [3];
    logic signed [255:0] dist_sq, rsum, fr, k, e, dd, lhs, rhs, sinv, cosq;
    logic [SIN_INV_W-1:0] sinv_used;
    logic [COS_SQ_W-1:0] cosq_used;
    logic sphere, cone;
    cull_result_t r;
    lp[0] = p.light_x;
    lp[1] = p.light_y;
    lp[2] = p.light_z;
    fc[0] = p.froxel_x;
    fc[1] = p.froxel_y;
    fc[2] = p.froxel_z;
    ax[0] = c.axis_x;
    ax[1] = c.axis_y;
    ax[2] = c.axis_z;
    sinv_used = (c.sin_inv > SIN_INV_CAP) ? SIN_INV_CAP : c.sin_inv;
    cosq_used = (c.cos_sq > COS_SQ_CAP) ? COS_SQ_CAP : c.cos_sq;
    sinv = sinv_used;
    cosq = cosq_used;
    fr = p.froxel_radius;
    rsum = p.light_radius;
    rsum = rsum + fr;
    dist_sq = 0;
    for (int i = 0; i < 3; i++) begin
      dist_sq = dist_sq + (lp[i] - fc[i]) * (lp[i] - fc[i]);
    end
    sphere = (rsum * rsum) >= dist_sq;
    // apex pulled back along the axis by froxel radius times sine inverse
    k = fr * sinv;
    e = 0;
    dd = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = ((fc[i] - lp[i]) <<< APEX_SHIFT) + k * ax[i];
      e = e + ax[i] * d[i];
      dd = dd + d[i] * d[i];
    end
    lhs = e * e;
    rhs = (dd * cosq) <<< RHS_SHIFT;
    cone = (lhs >= rhs) && (e > 0);
    r.sphere_hit = sphere;
    r.hit = sphere && (!c.spot_enable || cone);
    return r;
  endfunction

  function automatic longint spread(int unsigned bits);
    longint unsigned raw;
    raw = {$urandom, $urandom};
    return longint'(raw & ((64'd1 << (bits + 1)) - 1)) - (longint'(1) <<< bits);
  endfunction

  function automatic cull_pair_t make_pair(
    logic signed [CW-1:0] lx, logic signed [CW-1:0] ly, logic signed [CW-1:0] lz,
    logic [CW-2:0] lr,
    logic signed [CW-1:0] fx, logic signed [CW-1:0] fy, logic signed [CW-1:0] fz,
    logic [CW-2:0] fr);
    cull_pair_t p;
    p.light_x = lx;
    p.light_y = ly;
    p.light_z = lz;
    p.light_radius = lr;
    p.froxel_x = fx;
    p.froxel_y = fy;
    p.froxel_z = fz;
    p.froxel_radius = fr;
    return p;
  endfunction

  function automatic cull_pair_t random_pair(cull_cfg_t c);
    cull_pair_t p;
    int unsigned kind, mag, jbits;
    longint along, base;
    longint ax [3];
    logic signed [CW-1:0] lpos [3];
    logic signed [CW-1:0] cpos [3];
    p = make_pair($urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    kind = $urandom_range(99);
    // most pairs sit close together so both outcomes of each test show up
    if (kind >= 15) begin
      mag = $urandom_range(28, 2);
      jbits = (mag > 9) ? mag - $urandom_range(8, 1) : 1;
      p.light_radius = $urandom & ((32'd1 << mag) - 1);
      p.froxel_radius = $urandom & ((32'd1 << mag) - 1);
      ax[0] = c.axis_x;
      ax[1] = c.axis_y;
      ax[2] = c.axis_z;
      along = spread(mag) + (longint'(1) <<< (mag - 1));
      for (int i = 0; i < 3; i++) begin
        base = spread(29);
        lpos[i] = base;
        if (kind < 60) cpos[i] = base + ((ax[i] * along) >>> 14) + spread(jbits);
        else cpos[i] = base + spread(mag + 1);
      end
      p.light_x = lpos[0];
      p.light_y = lpos[1];
      p.light_z = lpos[2];
      p.froxel_x = cpos[0];
      p.froxel_y = cpos[1];
      p.froxel_z = cpos[2];
    end
    return p;
  endfunction

  function automatic cull_cfg_t random_cone_config();
    cull_cfg_t c;
    real vx, vy, vz, len, cs, sn;
    int unsigned pick;
    logic signed [AXIS_W-1:0] sgn;
    c.spot_enable = 1'b1;
    vx = $urandom_range(20000) / 10000.0 - 1.0;
    vy = $urandom_range(20000) / 10000.0 - 1.0;
    vz = $urandom_range(20000) / 10000.0 - 1.0;
    len = $sqrt(vx * vx + vy * vy + vz * vz);
    if (len < 0.01) begin
      vx = 0.0;
      vy = 0.0;
      vz = -1.0;
      len = 1.0;
    end
    c.axis_x = $rtoi(vx / len * 16384.0);
    c.axis_y = $rtoi(vy / len * 16384.0);
    c.axis_z = $rtoi(vz / len * 16384.0);
    pick = $urandom_range(5);
    if (pick == 0) begin
      c.axis_x = $urandom;
      c.axis_y = $urandom;
      c.axis_z = $urandom;
    end else if (pick == 1) begin
      c.axis_x = '0;
      c.axis_y = '0;
      c.axis_z = '0;
      sgn = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      case ($urandom_range(2))
        0: c.axis_x = sgn;
        1: c.axis_y = sgn;
        default: c.axis_z = sgn;
      endcase
    end
    c.cos_sq = $urandom_range(65535);
    cs = c.cos_sq / 65536.0;
    sn = $sqrt(1.0 - cs);
    if (sn * 8388607.0 < 65536.0) c.sin_inv = '1;
    else c.sin_inv = $rtoi(65536.0 / sn);
    if ($urandom_range(3) == 0) c.sin_inv = $urandom;
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    if (error_count < MAX_REPORTS) $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_config(cull_cfg_t c);
    logic [CFG_DATA_W-1:0] noise;
    noise = $urandom;
    write_reg(REG_SPOT_ENABLE, {noise[CFG_DATA_W-1:1], c.spot_enable});
    write_reg(REG_AXIS_X, {noise[CFG_DATA_W-1:AXIS_W], c.axis_x});
    write_reg(REG_AXIS_Y, {noise[CFG_DATA_W-1:AXIS_W], c.axis_y});
    write_reg(REG_AXIS_Z, {noise[CFG_DATA_W-1:AXIS_W], c.axis_z});
    write_reg(REG_SIN_INV, c.sin_inv);
    write_reg(REG_COS_SQ, {noise[CFG_DATA_W-1:COS_SQ_W], c.cos_sq});
    // writes to unmapped indexes must leave everything alone
    write_reg(REG_UNUSED_LO, $urandom);
    write_reg(REG_UNUSED_HI, $urandom);
    cfg_we_i <= 1'b0;
    cfg_model = c;
    @(posedge clk_i);
  endtask

  task automatic send_pair(cull_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      pair_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pair_if.valid <= 1'b1;
    pair_if.light_x <= p.light_x;
    pair_if.light_y <= p.light_y;
    pair_if.light_z <= p.light_z;
    pair_if.light_radius <= p.light_radius;
    pair_if.froxel_center_x <= p.froxel_x;
    pair_if.froxel_center_y <= p.froxel_y;
    pair_if.froxel_center_z <= p.froxel_z;
    pair_if.froxel_radius <= p.froxel_radius;
    do @(posedge clk_i); while (pair_if.ready !== 1'b1);
    expected_q.push_back(cull_predict(p, cfg_model));
  endtask

  task automatic drain_results();
    int n;
    pair_if.valid <= 1'b0;
    n = 0;
    while (expected_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
      expected_q.delete();
    end
  endtask

  task automatic test_sphere_defaults();
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(MAXC, MAXC, MAXC, MAXR, MINC, MINC, MINC, MAXR));
    send_pair(make_pair(0, 0, 0, 3 * U, 5 * U, 0, 0, 2 * U));
    send_pair(make_pair(0, 0, 0, 3 * U, 5 * U + 1, 0, 0, 2 * U));
    send_pair(make_pair(MINC, MINC, MINC, 0, MINC, MINC, MINC, 0));
    send_pair(make_pair(-7 * U, 2 * U, MAXC, MAXR, -7 * U, 2 * U, MAXC, 0));
    drain_results();
  endtask

  task automatic test_spot_cone();
    apply_config('{1'b1, 16'sd0, 16'sd0, -16'sd16384, 23'd131072, 16'd49152});
    // sphere miss although the froxel lies inside the cone
    send_pair(make_pair(0, 0, 0, U, 0, 0, -100 * U, U));
    send_pair(make_pair(0, 0, 0, 10 * U, 0, 0, -5 * U, U));
    send_pair(make_pair(0, 0, 0, 10 * U, 0, 0, 5 * U, U));
    send_pair(make_pair(0, 0, 0, 10 * U, 5 * U, 0, 0, U));
    send_pair(make_pair(0, 0, 0, 10 * U, 5 * U, 0, 0, 0));
    drain_results();
  endtask

  task automatic test_cone_caps();
    // both angle terms above their caps
    apply_config('{1'b1, 16'sd0, 16'sd0, -16'sd16384, 23'h7FFFFF, 16'hFFFF});
    send_pair(make_pair(0, 0, 0, 10 * U, 0, 0, -5 * U, 0));
    send_pair(make_pair(0, 0, 0, 10 * U, U / 8, 0, -5 * U, 0));
    send_pair(make_pair(MINC, 0, 0, MAXR, MAXC, 0, 0, MAXR));
    send_pair(make_pair(0, 0, 0, MAXR, 0, 0, MINC, MAXR));
    drain_results();
  endtask

  task automatic test_odd_axes();
    // axis longer than unit length
    apply_config('{1'b1, 16'sd16384, 16'sd16384, 16'sd16384, 23'd92682, 16'd32768});
    send_pair(make_pair(0, 0, 0, 4 * U, U, U, U, U));
    send_pair(make_pair(0, 0, 0, 4 * U, -U, -U, -U, U));
    drain_results();
    // zero axis gives a zero dot product
    apply_config('{1'b1, 16'sd0, 16'sd0, 16'sd0, 23'd0, 16'd0});
    send_pair(make_pair(0, 0, 0, 4 * U, U, 0, 0, U));
    send_pair(make_pair(MAXC, MINC, MAXC, MAXR, MINC, MAXC, MINC, MAXR));
    drain_results();
    apply_config('{1'b1, -16'sd16384, 16'sd16384, 16'sd0, 23'd0, 16'd0});
    send_pair(make_pair(0, 0, 0, 4 * U, -U, U, 0, U));
    send_pair(make_pair(0, 0, 0, 4 * U, U, -U, 0, U));
    drain_results();
  endtask

  task automatic test_random_phases();
    cull_cfg_t c;
    for (int ph = 0; ph < 6; ph++) begin
      c = random_cone_config();
      case (ph)
        0: c.spot_enable = 1'b0;
        2: begin
          c.cos_sq = COS_SQ_CAP;
          c.sin_inv = SIN_INV_CAP;
        end
        3: begin
          c.cos_sq = '0;
          c.sin_inv = '0;
        end
        4: begin
          c.cos_sq = '1;
          c.sin_inv = '1;
        end
        default: ;
      endcase
      if (ph < 2) begin
        send_idle_pct = 21;
        recv_idle_pct = 71;
      end else if (ph < 4) begin
        send_idle_pct = 71;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_config(c);
      repeat (RANDOM_PER_PHASE) send_pair(random_pair(cfg_model));
      drain_results();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_config(random_cone_config());
    // receiver stalls long enough for the pipe to fill and block the input
    hold_left = HOLD_CYCLES;
    repeat (BURST_ITEMS) send_pair(random_pair(cfg_model));
    drain_results();
  endtask

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cull_result_t want;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", result_count));
      end else begin
        want = expected_q.pop_front();
        if (res_if.hit !== want.hit)
          report_mismatch($sformatf("result %0d hit %b, expected %b",
                                    result_count, res_if.hit, want.hit));
        if (res_if.sphere_hit !== want.sphere_hit)
          report_mismatch($sformatf("result %0d sphere_hit %b, expected %b",
                                    result_count, res_if.sphere_hit, want.sphere_hit));
      end
      result_count++;
    end
  end

  always @(posedge clk_i) begin
    if ((pair_if.valid === 1'b1 && pair_if.ready === 1'b1) ||
        (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
      stall_count <= 0;
    end else if (stall_count >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_SPOT_ENABLE;
    cfg_wdata_i <= '0;
    pair_if.valid <= 1'b0;
    pair_if.light_x <= '0;
    pair_if.light_y <= '0;
    pair_if.light_z <= '0;
    pair_if.light_radius <= '0;
    pair_if.froxel_center_x <= '0;
    pair_if.froxel_center_y <= '0;
    pair_if.froxel_center_z <= '0;
    pair_if.froxel_radius <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_sphere_defaults();
    test_spot_cone();
    test_cone_caps();
    test_odd_axes();
    test_random_phases();
    test_backpressure();

    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
